### sv/gpe_pkg.sv
package gpe_pkg;

    // datapath sizing
    localparam int DATA_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 12;

    // phase constants, radians in Q.24
    localparam longint TWO_PI_Q24  = 105414357;
    localparam longint PI_Q24      = 52707179;
    localparam longint HALF_PI_Q24 = 26353589;

    // cordic gain compensation 1/K(n), Q.30 terms rounded to Q.24
    localparam longint KINV_INF_Q30  = 652032874;
    localparam longint KINV_CORR_Q30 = 434688583;
    localparam longint KINV_Q24 =
        (KINV_INF_Q30 + (KINV_CORR_Q30 >> (2 * CORDIC_STAGES)) + 32) >> 6;
    localparam int KINV_W = 24;
    localparam logic [KINV_W-1:0] KINV = KINV_W'(KINV_Q24);

    // x/y carry Q.36 with cordic growth headroom, z carries Q.30
    localparam int XW    = DATA_WIDTH + 26;
    localparam int ZW    = 32;
    // reduced phase residue, signed Q.24 in [-pi, pi)
    localparam int RW    = 28;
    // phase reduction: offset by whole turns, then binary compare-subtract
    localparam int     RED_STEPS  = 5;
    localparam longint RED_OFFSET = 12 * TWO_PI_Q24;

    // index into the arctangent table
    localparam int IDX_W = 5;

    // saturation limits for DATA_WIDTH signed bits
    localparam longint SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    // atan(2^-i) in Q.30
    localparam logic signed [ZW-1:0] ATAN_Q30 [30] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8,
        32'sd4,         32'sd2
    };

    // one antenna element
    typedef struct packed {
        logic signed [15:0] noise_amplitude;
        logic signed [15:0] noise_phase;
        logic signed [15:0] nominal_gain;
        logic        [14:0] gain_spread;
        logic signed [15:0] nominal_phase;
        logic        [14:0] phase_spread;
        logic               last_in;
    } t_in_item;

    // one complex weight
    typedef struct packed {
        logic signed [15:0] weight_real;
        logic signed [15:0] weight_imag;
        logic               saturated;
        logic               last_out;
    } t_out_item;

    // vector handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 flag;
        logic                 last;
    } t_rot;

    // clamp to DATA_WIDTH signed bits, msb of result is the clip flag
    function automatic logic [DATA_WIDTH:0] sat_dw(input logic signed [63:0] v);
        logic [DATA_WIDTH:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, DATA_WIDTH'(SAT_HI)};
        end else if (v < SAT_LO) begin
            res = {1'b1, DATA_WIDTH'(SAT_LO)};
        end else begin
            res = {1'b0, v[DATA_WIDTH-1:0]};
        end
        return res;
    endfunction

endpackage

### sv/gpe_front.sv
module gpe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gpe_pkg::t_in_item i_item,
    output gpe_pkg::t_rot   o_rot
);

    typedef struct packed {
        logic                                  valid;
        logic [31:0]                           r;
        logic signed [gpe_pkg::DATA_WIDTH-1:0] amp;
        logic                                  flag;
        logic                                  last;
    } t_red;

    // stage 1: products
    logic               r_v1;
    logic signed [31:0] r_pa;
    logic signed [31:0] r_pp;
    logic signed [15:0] r_gain;
    logic signed [15:0] r_nph;
    logic               r_last1;
    logic signed [31:0] n_pa;
    logic signed [31:0] n_pp;

    assign n_pa = 32'(i_item.noise_amplitude) * 32'($signed({1'b0, i_item.gain_spread}));
    assign n_pp = 32'(i_item.noise_phase) * 32'($signed({1'b0, i_item.phase_spread}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_pa    <= n_pa;
        r_pp    <= n_pp;
        r_gain  <= i_item.nominal_gain;
        r_nph   <= i_item.nominal_phase;
        r_last1 <= i_item.last_in;
    end

    // stage 2: amplitude with rounding and clip, phase offset to non-negative
    logic signed [33:0] n_amp_sum;
    logic signed [33:0] n_pofs;
    t_red               r_red [0:gpe_pkg::RED_STEPS];
    t_red               n_red [0:gpe_pkg::RED_STEPS];

    assign n_amp_sum = ((34'(r_pa) + 34'sd2048) >>> gpe_pkg::FRAC_BITS) + 34'(r_gain);
    assign n_pofs    = 34'(r_pp) + (34'(r_nph) <<< gpe_pkg::FRAC_BITS)
                     + 34'(gpe_pkg::RED_OFFSET);

    // phase reduction cells, stage k takes off 2^(RED_STEPS-1-k) turns when the residue allows
    always_comb begin
        n_red[0].valid = r_v1;
        n_red[0].r     = n_pofs[31:0];
        {n_red[0].flag, n_red[0].amp} = gpe_pkg::sat_dw(64'(n_amp_sum));
        n_red[0].last  = r_last1;
        for (int k = 0; k < gpe_pkg::RED_STEPS; k++) begin
            n_red[k+1] = r_red[k];
            if (r_red[k].r >= 32'(gpe_pkg::TWO_PI_Q24 <<< (gpe_pkg::RED_STEPS - 1 - k))) begin
                n_red[k+1].r = r_red[k].r
                             - 32'(gpe_pkg::TWO_PI_Q24 <<< (gpe_pkg::RED_STEPS - 1 - k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= gpe_pkg::RED_STEPS; k++) begin
            if (!i_rst_n) begin
                r_red[k] <= '0;
            end else begin
                r_red[k] <= n_red[k];
            end
        end
    end

    // fold into +-pi/2, start vector scaled by 1/K
    logic signed [gpe_pkg::RW-1:0] n_res;
    logic signed [gpe_pkg::RW-1:0] n_half;
    logic                          n_neg;
    gpe_pkg::t_rot                 n_rot;
    gpe_pkg::t_rot                 r_rot;

    always_comb begin
        n_res = $signed({1'b0, r_red[gpe_pkg::RED_STEPS].r[gpe_pkg::RW-2:0]});
        if (n_res >= gpe_pkg::RW'(gpe_pkg::PI_Q24)) begin
            n_res = n_res - gpe_pkg::RW'(gpe_pkg::TWO_PI_Q24);
        end
        n_half = n_res;
        n_neg  = 1'b0;
        if (n_res > gpe_pkg::RW'(gpe_pkg::HALF_PI_Q24)) begin
            n_half = n_res - gpe_pkg::RW'(gpe_pkg::PI_Q24);
            n_neg  = 1'b1;
        end else if (n_res < -gpe_pkg::RW'(gpe_pkg::HALF_PI_Q24)) begin
            n_half = n_res + gpe_pkg::RW'(gpe_pkg::PI_Q24);
            n_neg  = 1'b1;
        end
        n_rot.valid = r_red[gpe_pkg::RED_STEPS].valid;
        n_rot.x     = gpe_pkg::XW'(r_red[gpe_pkg::RED_STEPS].amp)
                    * gpe_pkg::XW'($signed({1'b0, gpe_pkg::KINV}));
        n_rot.y     = '0;
        n_rot.z     = gpe_pkg::ZW'(n_half) <<< 6;
        n_rot.neg   = n_neg;
        n_rot.flag  = r_red[gpe_pkg::RED_STEPS].flag;
        n_rot.last  = r_red[gpe_pkg::RED_STEPS].last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= '0;
        end else begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

`ifndef ASSERT_OFF
    a_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_red[gpe_pkg::RED_STEPS].valid |->
            r_red[gpe_pkg::RED_STEPS].r < 32'(gpe_pkg::TWO_PI_Q24))
        else $error("phase residue not below one turn");

    a_amp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_red[0].valid && r_red[0].flag) |->
            (r_red[0].amp == gpe_pkg::DATA_WIDTH'(gpe_pkg::SAT_HI)) ||
            (r_red[0].amp == gpe_pkg::DATA_WIDTH'(gpe_pkg::SAT_LO)))
        else $error("amplitude clip flag without rail value");

    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rot.valid |->
            (r_rot.z <= gpe_pkg::ZW'(gpe_pkg::HALF_PI_Q24 * 64)) &&
            (r_rot.z >= -gpe_pkg::ZW'(gpe_pkg::HALF_PI_Q24 * 64)))
        else $error("start angle outside half turn");
`endif

endmodule

### sv/gpe_cordic_cell.sv
module gpe_cordic_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [gpe_pkg::IDX_W-1:0] i_idx,
    input  gpe_pkg::t_rot             i_rot,
    output gpe_pkg::t_rot             o_rot
);

    logic signed [gpe_pkg::XW-1:0] n_dx;
    logic signed [gpe_pkg::XW-1:0] n_dy;
    logic signed [gpe_pkg::ZW-1:0] n_atan;
    gpe_pkg::t_rot                 n_rot;
    gpe_pkg::t_rot                 r_rot;

    // one micro-rotation, direction from the sign of the residual angle
    always_comb begin
        n_dx   = i_rot.y >>> i_idx;
        n_dy   = i_rot.x >>> i_idx;
        n_atan = gpe_pkg::ATAN_Q30[i_idx];
        n_rot  = i_rot;
        if (!i_rot.z[gpe_pkg::ZW-1]) begin
            n_rot.x = i_rot.x - n_dx;
            n_rot.y = i_rot.y + n_dy;
            n_rot.z = i_rot.z - n_atan;
        end else begin
            n_rot.x = i_rot.x + n_dx;
            n_rot.y = i_rot.y - n_dy;
            n_rot.z = i_rot.z + n_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= '0;
        end else begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

### sv/gpe_back.sv
module gpe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gpe_pkg::t_rot      i_rot,
    output logic               o_done,
    output gpe_pkg::t_out_item o_result
);

    localparam logic signed [gpe_pkg::XW-1:0] RND = gpe_pkg::XW'(64'sd8388608);

    // undo the half-turn fold
    logic                          r_v;
    logic signed [gpe_pkg::XW-1:0] r_xn;
    logic signed [gpe_pkg::XW-1:0] r_yn;
    logic                          r_flag;
    logic                          r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_rot.valid;
        end
        r_xn   <= i_rot.neg ? -i_rot.x : i_rot.x;
        r_yn   <= i_rot.neg ? -i_rot.y : i_rot.y;
        r_flag <= i_rot.flag;
        r_last <= i_rot.last;
    end

    // round to Q.12 and clip
    logic signed [gpe_pkg::XW-1:0]         n_xr;
    logic signed [gpe_pkg::XW-1:0]         n_yr;
    logic signed [gpe_pkg::DATA_WIDTH-1:0] n_re;
    logic signed [gpe_pkg::DATA_WIDTH-1:0] n_im;
    logic                                  n_re_clip;
    logic                                  n_im_clip;
    gpe_pkg::t_out_item                    n_result;
    gpe_pkg::t_out_item                    r_result;
    logic                                  r_done;

    always_comb begin
        n_xr = (r_xn + RND) >>> 24;
        n_yr = (r_yn + RND) >>> 24;
        {n_re_clip, n_re} = gpe_pkg::sat_dw(64'(n_xr));
        {n_im_clip, n_im} = gpe_pkg::sat_dw(64'(n_yr));
        n_result.weight_real = 16'(n_re);
        n_result.weight_imag = 16'(n_im);
        n_result.saturated   = r_flag | n_re_clip | n_im_clip;
        n_result.last_out    = r_last;
    end

    // result strobe, one cycle per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### sv/gain_phase_error_weight_top.sv
// gain and phase error weight: amplitude and phase with noise, cordic rotation
// pipeline: 2 multiply/sum stages, 5 phase reduction stages, 1 fold stage,
//   one cell per cordic stage, 2 output stages; o_done is the result strobe
//   from the last output stage
// throughput: one element per cycle, busy stays low, fully pipelined cell chain
// reset: synchronous active low, clears all stage valid bits; no transfer in flight
module gain_phase_error_weight_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gpe_pkg::t_in_item  i_item,
    output logic               o_done,
    output gpe_pkg::t_out_item o_result
);

    gpe_pkg::t_rot w_rot [0:gpe_pkg::CORDIC_STAGES];

    // pipeline never stalls
    assign busy = 1'b0;

    // products, amplitude, phase reduction, start vector
    gpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_rot   (w_rot[0])
    );

    // chain of rotation cells
    for (genvar g = 0; g < gpe_pkg::CORDIC_STAGES; g++) begin : g_cell
        gpe_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (gpe_pkg::IDX_W'(g)),
            .i_rot   (w_rot[g]),
            .o_rot   (w_rot[g+1])
        );
    end

    // unfold, round, clip, output register
    gpe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rot    (w_rot[gpe_pkg::CORDIC_STAGES]),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef gpe_pkg::t_in_item  t_in_item;
    typedef gpe_pkg::t_out_item t_out_item;

    // phase constants in Q.24 radians
    localparam longint FULL_TURN_Q24    = 105414357;
    localparam longint HALF_TURN_Q24    = 52707179;
    localparam longint QUARTER_TURN_Q24 = 26353589;

    // gain compensation terms in Q.30
    localparam longint GAIN_COMP_Q30  = 652032874;
    localparam longint GAIN_CORR_Q30  = 434688583;

    // arctangent of 2^-i in Q.30
    localparam longint ARCTAN_Q30 [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516,  16775851,  8388437,   4194283,   2097149,
        1048576,   524288,    262144,    131072,    65536,
        32768,     16384,     8192,      4096,      2048,
        1024,      512,       256,       128,       64,
        32,        16,        8,         4,         2
    };

    // expected weights for accepted elements, checked in arrival order
    class weight_scoreboard;
        t_out_item   weight_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // clamp to DATA_WIDTH signed bits and note a clip
        function longint clamp_dw(longint v, inout bit clip);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (gpe_pkg::DATA_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                clip = 1'b1;
                return hi;
            end
            if (v < lo) begin
                clip = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // amplitude and phase with noise, fold to +-pi/2, rotate by cordic
        function t_out_item predict_weight(t_in_item e);
            longint    na, np, gain, gs, nph, ps;
            longint    amp, ph, resid, z, x, y, dx, dy, kinv, re, im;
            bit        clip;
            bit        fold;
            t_out_item w;
            clip = 1'b0;
            fold = 1'b0;
            na   = $signed(e.noise_amplitude);
            np   = $signed(e.noise_phase);
            gain = $signed(e.nominal_gain);
            gs   = e.gain_spread;
            nph  = $signed(e.nominal_phase);
            ps   = e.phase_spread;

            // amplitude: round product to Q.12 half up, add gain, clamp
            amp = ((na * gs + 2048) >>> 12) + gain;
            amp = clamp_dw(amp, clip);

            // exact phase in Q.24, reduce to [-pi, pi), fold into +-pi/2
            ph    = np * ps + nph * 4096;
            resid = ph % FULL_TURN_Q24;
            if (resid < 0) resid += FULL_TURN_Q24;
            if (resid >= HALF_TURN_Q24) resid -= FULL_TURN_Q24;
            if (resid > QUARTER_TURN_Q24) begin
                resid -= HALF_TURN_Q24;
                fold = 1'b1;
            end else if (resid < -QUARTER_TURN_Q24) begin
                resid += HALF_TURN_Q24;
                fold = 1'b1;
            end
            z = resid * 64;

            // start vector scaled by inverse cordic gain
            kinv = (GAIN_COMP_Q30 + (GAIN_CORR_Q30 >>> (2 * gpe_pkg::CORDIC_STAGES)) + 32)
                   >>> 6;
            x = amp * kinv;
            y = 0;
            for (int i = 0; i < gpe_pkg::CORDIC_STAGES && i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= ARCTAN_Q30[i];
                end else begin
                    x += dx;
                    y -= dy;
                    z += ARCTAN_Q30[i];
                end
            end
            if (fold) begin
                x = -x;
                y = -y;
            end

            // round Q.36 to Q.12, clamp, keep low 16 bits
            re = clamp_dw((x + (longint'(1) <<< 23)) >>> 24, clip);
            im = clamp_dw((y + (longint'(1) <<< 23)) >>> 24, clip);
            w.weight_real = re[15:0];
            w.weight_imag = im[15:0];
            w.saturated   = clip;
            w.last_out    = e.last_in;
            return w;
        endfunction

        function void add_element(t_in_item e);
            weight_q.push_back(predict_weight(e));
        endfunction

        function void check_weight(t_out_item got);
            t_out_item want;
            if (weight_q.size() == 0) begin
                $display("%0t: weight with no element pending: re %0d im %0d", $time,
                         got.weight_real, got.weight_imag);
                errors++;
                return;
            end
            want = weight_q.pop_front();
            if (got.weight_real !== want.weight_real) begin
                $display("%0t: weight_real expected %0d got %0d", $time,
                         want.weight_real, got.weight_real);
                errors++;
            end
            if (got.weight_imag !== want.weight_imag) begin
                $display("%0t: weight_imag expected %0d got %0d", $time,
                         want.weight_imag, got.weight_imag);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated expected %0b got %0b", $time,
                         want.saturated, got.saturated);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $display("%0t: last_out expected %0b got %0b", $time,
                         want.last_out, got.last_out);
                errors++;
            end
        endfunction

        function int pending();
            return weight_q.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    weight_scoreboard board;

    gain_phase_error_weight_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // result side, sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            board.check_weight(o_result);
        end
    end

    function automatic t_in_item make_element(int na, int np, int gain, int gs,
                                              int nph, int ps, bit last);
        t_in_item e;
        e.noise_amplitude = 16'(na);
        e.noise_phase     = 16'(np);
        e.nominal_gain    = 16'(gain);
        e.gain_spread     = 15'(gs);
        e.nominal_phase   = 16'(nph);
        e.phase_spread    = 15'(ps);
        e.last_in         = last;
        return e;
    endfunction

    // mostly realistic elements, a quarter with every field at full range
    function automatic t_in_item random_element();
        t_in_item e;
        if ($urandom_range(0, 3) == 0) begin
            e = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom}));
        end else begin
            e = make_element(int'($urandom_range(0, 24576)) - 12288,
                             int'($urandom_range(0, 24576)) - 12288,
                             int'($urandom_range(0, 12288)) - 2048,
                             $urandom_range(0, 1024),
                             int'($urandom_range(0, 25736)) - 12868,
                             $urandom_range(0, 2048),
                             $urandom_range(0, 15) == 0);
        end
        return e;
    endfunction

    // idle gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one element transfer, then an optional idle gap
    task automatic send_element(input t_in_item e, input int unsigned gap);
        start  <= 1'b1;
        i_item <= e;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.add_element(e);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zeros, extremes, quadrant edges, folding and clipping
        send_element(make_element(0, 0, 0, 0, 0, 0, 0), pick_gap());
        send_element(make_element(0, 0, 4096, 0, 0, 0, 1), pick_gap());
        send_element(make_element(32767, 0, 32767, 32767, 0, 0, 0), pick_gap());
        send_element(make_element(-32768, 0, -32768, 32767, 0, 0, 0), pick_gap());
        // exactly +pi/2, then one step past it
        send_element(make_element(0, 1, 4096, 0, 6433, 4021, 0), pick_gap());
        send_element(make_element(0, 1, 4096, 0, 6433, 4022, 0), pick_gap());
        // exactly +pi and -pi
        send_element(make_element(0, 1, 4096, 0, 12867, 3947, 0), pick_gap());
        send_element(make_element(0, -1, 4096, 0, -12867, 3947, 0), pick_gap());
        // negative amplitude
        send_element(make_element(0, 0, -4096, 0, 2867, 0, 0), pick_gap());
        // full negative amplitude at pi flips to positive full scale
        send_element(make_element(0, 1, -32768, 0, 12867, 3947, 0), pick_gap());
        send_element(make_element(0, 0, 32767, 0, 0, 0, 1), pick_gap());
        send_element(make_element(0, 0, -32768, 0, 0, 0, 0), pick_gap());
        // largest phases of both signs
        send_element(make_element(32767, 32767, 0, 32767, 32767, 32767, 0), pick_gap());
        send_element(make_element(-32768, -32768, 0, 32767, -32768, 32767, 1), pick_gap());
        send_element(make_element(0, 0, 4096, 0, 25736, 0, 0), pick_gap());
        send_element(make_element(0, 0, 4096, 0, -6434, 0, 0), pick_gap());
        send_element(make_element(4096, -4096, 4096, 4096, 3217, 1024, 0), pick_gap());
        send_element(make_element(-32768, 32767, 32767, 32767, 0, 32767, 0), pick_gap());
        send_element(make_element(0, 0, 32767, 0, 3217, 0, 0), pick_gap());

        // random elements, with back to back stretches
        for (int n = 0; n < 600; n++) begin
            send_element(random_element(), (n % 100 < 30) ? 0 : pick_gap());
        end
        start <= 1'b0;

        // drain the pipeline
        while (board.pending() != 0) @(posedge i_clk);
        repeat (gpe_pkg::CORDIC_STAGES + 20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
